>>> hdl/lidar_zone_obstacle_detector_top_macros.svh
// Assertion macros for the lidar zone obstacle detector.
// Used by the checker module; no other dependencies.
`ifndef LIDAR_ZONE_OBSTACLE_DETECTOR_TOP_MACROS_SVH
`define LIDAR_ZONE_OBSTACLE_DETECTOR_TOP_MACROS_SVH

// Checked only while reset is released.
`define LZOD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lzod assertion failed");

// Checked on every edge, reset included.
`define LZOD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lzod assertion failed");

`endif

>>> hdl/lzod_pkg.sv
// Shared types, constants and the sine table generator of the lidar zone detector.
// No dependencies.
`default_nettype none

package lzod_pkg;

    localparam int unsigned FRONT_LIMIT_MM = 1000;
    localparam int unsigned SIDE_LIMIT_MM  = 500;
    localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN      = 32'h8000_0000;

    typedef enum logic [2:0] {
        CFG_SCAN_START = 3'd0,
        CFG_ANGLE_STEP = 3'd1,
        CFG_MOUNT_YAW  = 3'd2,
        CFG_CLOSE      = 3'd3,
        CFG_MID        = 3'd4,
        CFG_FAR        = 3'd5,
        CFG_SIDE       = 3'd6,
        CFG_REAR       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] sample_range;
        logic        sample_valid;
        logic        scan_last;
    } t_in_item;

    typedef struct packed {
        logic close_clear;
        logic mid_clear;
        logic far_clear;
    } t_out_item;

    // angle stage: beam angle of the sample
    typedef struct packed {
        logic        vld;
        logic        last;
        logic        usable;
        logic [15:0] range;
        logic [31:0] theta;
    } t_s1;

    // table stage: signed Q15 sine and cosine
    typedef struct packed {
        logic               vld;
        logic               last;
        logic               usable;
        logic [15:0]        range;
        logic signed [16:0] sin_q15;
        logic signed [16:0] cos_q15;
    } t_s2;

    // product stage
    typedef struct packed {
        logic               vld;
        logic               last;
        logic               usable;
        logic signed [33:0] px;
        logic signed [33:0] py;
    } t_s3;

    // coordinate stage, mm
    typedef struct packed {
        logic               vld;
        logic               last;
        logic               usable;
        logic signed [17:0] x;
        logic [16:0]        ax;
        logic [16:0]        ay;
    } t_s4;

    // Quarter-wave sine point r in Q15; evaluated at elaboration only.
    // The peak of the wave is exactly 1.0 (32768), so the result is 17 bits.
    function automatic logic [16:0] quarter_sine(input int unsigned r, input int unsigned tb);
        longint z;
        longint z2;
        longint inner;
        longint mid;
        longint s;
        z     = longint'(r) << (17 - tb);
        z2    = (z * z) >>> 15;
        inner = 64'sd21024 - ((64'sd2320 * z2) >>> 15);
        mid   = 64'sd51472 - ((z2 * inner) >>> 15);
        s     = (z * mid) >>> 15;
        return 17'(s);
    endfunction

endpackage

`default_nettype wire

>>> hdl/lzod_angle.sv
// Angle stage: running angle offset and the registered beam angle per sample.
// Depends on lzod_pkg.
`default_nettype none

module lzod_angle (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire lzod_pkg::t_in_item i_in_item,
    input  wire logic [31:0]      i_scan_start,
    input  wire logic [31:0]      i_angle_step,
    input  wire logic [31:0]      i_mount_yaw,
    input  wire logic             i_load2,
    output logic                  o_in_ready,
    output lzod_pkg::t_s1         o_s1
);
    import lzod_pkg::*;

    logic [31:0] r_offset;
    logic [31:0] n_offset;
    t_s1         r_s1;
    t_s1         n_s1;
    logic        w_en1;
    logic        w_fire;

    assign w_en1      = !r_s1.vld || i_load2;
    assign w_fire     = i_in_valid && w_en1;
    assign o_in_ready = w_en1;
    assign o_s1       = r_s1;

    always_comb begin
        n_offset = r_offset;
        n_s1     = r_s1;
        if (w_fire) begin
            n_offset = i_in_item.scan_last ? 32'd0 : r_offset + i_angle_step;
        end
        if (w_en1) begin
            n_s1.vld    = w_fire;
            n_s1.last   = i_in_item.scan_last;
            n_s1.usable = i_in_item.sample_valid && (i_in_item.sample_range != 16'd0);
            n_s1.range  = i_in_item.sample_range;
            n_s1.theta  = i_scan_start + r_offset + i_mount_yaw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_s1     <= '0;
        end else begin
            r_offset <= n_offset;
            r_s1     <= n_s1;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lzod_project.sv
// Projection stages: sine table lookup, range products and x/y in mm.
// Depends on lzod_pkg.
`default_nettype none

module lzod_project #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lzod_pkg::t_s1 i_s1,
    input  wire logic          i_drain,
    output logic               o_load2,
    output lzod_pkg::t_s4      o_s4
);
    import lzod_pkg::*;

    localparam int TB  = TRIG_TABLE_BITS;
    localparam int QTR = 1 << (TB - 2);

    logic [16:0]          w_sin_tab [0:QTR];
    logic [31:0]          w_rnd;
    logic [TB-1:0]        w_k;
    logic [TB-1:0]        w_kc;
    logic [TB-2:0]        w_idx_s;
    logic [TB-2:0]        w_idx_c;
    logic signed [16:0]   w_mag_s;
    logic signed [16:0]   w_mag_c;
    logic                 w_front;
    logic signed [16:0]   w_rng_s;
    logic signed [33:0]   w_sum_x;
    logic signed [33:0]   w_sum_y;
    logic signed [17:0]   w_x;
    logic signed [17:0]   w_y;
    logic                 w_en2;
    logic                 w_en3;
    logic                 w_en4;
    t_s2                  r_s2;
    t_s2                  n_s2;
    t_s3                  r_s3;
    t_s3                  n_s3;
    t_s4                  r_s4;
    t_s4                  n_s4;

    for (genvar g = 0; g <= QTR; g++) begin : g_tab
        assign w_sin_tab[g] = quarter_sine(g, TB);
    end

    assign w_en4   = !r_s4.vld || i_drain;
    assign w_en3   = !r_s3.vld || w_en4;
    assign w_en2   = !r_s2.vld || w_en3;
    assign o_load2 = w_en2;
    assign o_s4    = r_s4;

    // round the angle to the nearest table step
    assign w_rnd   = i_s1.theta + (32'd1 << (31 - TB));
    assign w_k     = w_rnd[31 -: TB];
    assign w_kc    = w_k + TB'(QTR);
    assign w_front = (i_s1.theta + QUARTER_TURN) <= HALF_TURN;

    // odd quadrants read the quarter wave backwards
    assign w_idx_s = w_k[TB-2]  ? (TB-1)'(QTR) - {1'b0, w_k[TB-3:0]}  : {1'b0, w_k[TB-3:0]};
    assign w_idx_c = w_kc[TB-2] ? (TB-1)'(QTR) - {1'b0, w_kc[TB-3:0]} : {1'b0, w_kc[TB-3:0]};
    // table peaks at 32768, still positive as a 17-bit signed value
    assign w_mag_s = $signed(w_sin_tab[w_idx_s]);
    assign w_mag_c = $signed(w_sin_tab[w_idx_c]);

    assign w_rng_s = $signed({1'b0, r_s2.range});
    assign w_sum_x = r_s3.px + 34'sd16384;
    assign w_sum_y = r_s3.py + 34'sd16384;
    assign w_x     = w_sum_x[32:15];
    assign w_y     = w_sum_y[32:15];

    always_comb begin
        n_s2 = r_s2;
        n_s3 = r_s3;
        n_s4 = r_s4;
        if (w_en2) begin
            n_s2.vld     = i_s1.vld;
            n_s2.last    = i_s1.last;
            n_s2.usable  = i_s1.usable && w_front;
            n_s2.range   = i_s1.range;
            n_s2.sin_q15 = w_k[TB-1]  ? -w_mag_s : w_mag_s;
            n_s2.cos_q15 = w_kc[TB-1] ? -w_mag_c : w_mag_c;
        end
        if (w_en3) begin
            n_s3.vld    = r_s2.vld && w_en2;
            n_s3.last   = r_s2.last;
            n_s3.usable = r_s2.usable;
            n_s3.px     = w_rng_s * r_s2.cos_q15;
            n_s3.py     = w_rng_s * r_s2.sin_q15;
        end
        if (w_en4) begin
            n_s4.vld    = r_s3.vld && w_en3;
            n_s4.last   = r_s3.last;
            n_s4.usable = r_s3.usable;
            n_s4.x      = w_x;
            n_s4.ax     = w_x[17] ? 17'(-w_x) : 17'(w_x);
            n_s4.ay     = w_y[17] ? 17'(-w_y) : 17'(w_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lzod_zone.sv
// Zone stage: box tests, hit accumulation over a scan and the result register.
// Depends on lzod_pkg.
`default_nettype none

module lzod_zone (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lzod_pkg::t_s4      i_s4,
    input  wire logic [9:0]         i_close_reach,
    input  wire logic [9:0]         i_mid_reach,
    input  wire logic [9:0]         i_far_reach,
    input  wire logic [8:0]         i_side_half_width,
    input  wire logic signed [10:0] i_rear_limit,
    input  wire logic               i_out_ready,
    output logic                    o_drain,
    output logic                    o_out_valid,
    output lzod_pkg::t_out_item     o_out_item
);
    import lzod_pkg::*;

    logic               r_hit_c;
    logic               r_hit_m;
    logic               r_hit_f;
    logic               n_hit_c;
    logic               n_hit_m;
    logic               n_hit_f;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out_item;
    t_out_item          n_out_item;
    logic signed [17:0] w_rear;
    logic               w_box;
    logic               w_side;
    logic               w_c;
    logic               w_m;
    logic               w_f;

    assign o_drain     = i_s4.vld && (!i_s4.last || !r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_rear = 18'(i_rear_limit);
    assign w_box  = i_s4.usable && (i_s4.x > w_rear) && (i_s4.x < 18'sd1000)
                    && (i_s4.ay < 17'(SIDE_LIMIT_MM));
    assign w_side = i_s4.ay < {8'd0, i_side_half_width};
    // nested zones: a closer hit also marks every outer zone
    assign w_c = w_box && w_side && (i_s4.ax <= {7'd0, i_close_reach});
    assign w_m = w_c || (w_box && w_side && (i_s4.ax <= {7'd0, i_mid_reach}));
    assign w_f = w_m || (w_box && w_side && (i_s4.ax <= {7'd0, i_far_reach}));

    always_comb begin
        n_hit_c     = r_hit_c;
        n_hit_m     = r_hit_m;
        n_hit_f     = r_hit_f;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_drain) begin
            if (i_s4.last) begin
                n_out_valid            = 1'b1;
                n_out_item.close_clear = !(r_hit_c || w_c);
                n_out_item.mid_clear   = !(r_hit_m || w_m);
                n_out_item.far_clear   = !(r_hit_f || w_f);
                n_hit_c                = 1'b0;
                n_hit_m                = 1'b0;
                n_hit_f                = 1'b0;
            end else begin
                n_hit_c = r_hit_c || w_c;
                n_hit_m = r_hit_m || w_m;
                n_hit_f = r_hit_f || w_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_c     <= 1'b0;
            r_hit_m     <= 1'b0;
            r_hit_f     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hit_c     <= n_hit_c;
            r_hit_m     <= n_hit_m;
            r_hit_f     <= n_hit_f;
            r_out_valid <= n_out_valid;
        end
        r_out_item <= n_out_item;
    end

endmodule

`default_nettype wire

>>> hdl/lidar_zone_obstacle_detector_top.sv
// Top level of the lidar zone obstacle detector: configuration registers and stages.
// Depends on lzod_pkg, lzod_angle, lzod_project and lzod_zone.
`default_nettype none

// Usage
//  Input channel (i_in_valid / o_in_ready / i_in_item): one range sample per
//  transaction, with its validity bit and the end-of-scan mark.
//  Output channel (o_out_valid / i_out_ready / o_out_item): one transaction per
//  scan, sent for the sample marked last, carrying the close/mid/far clear flags.
//  Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): always
//  ready; write only while no sample is in flight.
//  Throughput: one sample per cycle unless a receiver stall backs up the input.
//  The pipeline is angle, table lookup, multiply, x/y scaling and zone test; a last
//  sample passes the angle, table, product and coordinate registers into the output register.
//  Reset (synchronous, active low) empties the pipeline, clears the angle offset
//  and the zone hits and loads the register defaults.
//  Receiver stall: a waiting result sits in the output register while samples
//  keep flowing; only another last sample arriving at the zone stage halts, and
//  the input backs up once all four stages behind it are full.
module lidar_zone_obstacle_detector_top #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire lzod_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output lzod_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data
);
    import lzod_pkg::*;

    logic [31:0]        r_scan_start;
    logic [31:0]        r_angle_step;
    logic [31:0]        r_mount_yaw;
    logic [9:0]         r_close_reach;
    logic [9:0]         r_mid_reach;
    logic [9:0]         r_far_reach;
    logic [8:0]         r_side_half;
    logic signed [10:0] r_rear_limit;
    t_s1                w_s1;
    t_s4                w_s4;
    logic               w_load2;
    logic               w_drain;

    // config writes go straight into the registers, nothing to back-pressure
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_start  <= '0;
            r_angle_step  <= '0;
            r_mount_yaw   <= '0;
            r_close_reach <= 10'd150;
            r_mid_reach   <= 10'd200;
            r_far_reach   <= 10'd300;
            r_side_half   <= 9'd250;
            r_rear_limit  <= -11'sd100;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCAN_START: r_scan_start  <= i_cfg_data;
                CFG_ANGLE_STEP: r_angle_step  <= i_cfg_data;
                CFG_MOUNT_YAW:  r_mount_yaw   <= i_cfg_data;
                CFG_CLOSE:      r_close_reach <= i_cfg_data[9:0];
                CFG_MID:        r_mid_reach   <= i_cfg_data[9:0];
                CFG_FAR:        r_far_reach   <= i_cfg_data[9:0];
                CFG_SIDE:       r_side_half   <= i_cfg_data[8:0];
                CFG_REAR:       r_rear_limit  <= $signed(i_cfg_data[10:0]);
                default: begin
                end
            endcase
        end
    end

    // beam angle = start + running offset + mount yaw, wraps mod one turn
    lzod_angle u_angle (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_scan_start (r_scan_start),
        .i_angle_step (r_angle_step),
        .i_mount_yaw  (r_mount_yaw),
        .i_load2      (w_load2),
        .o_in_ready   (o_in_ready),
        .o_s1         (w_s1)
    );

    // table lookup, range products, rounded x/y in mm
    lzod_project #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (w_s1),
        .i_drain (w_drain),
        .o_load2 (w_load2),
        .o_s4    (w_s4)
    );

    // box tests, per-scan hit flags and the output register
    lzod_zone u_zone (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s4              (w_s4),
        .i_close_reach     (r_close_reach),
        .i_mid_reach       (r_mid_reach),
        .i_far_reach       (r_far_reach),
        .i_side_half_width (r_side_half),
        .i_rear_limit      (r_rear_limit),
        .i_out_ready       (i_out_ready),
        .o_drain           (w_drain),
        .o_out_valid       (o_out_valid),
        .o_out_item        (o_out_item)
    );

endmodule

`default_nettype wire

>>> hdl/lzod_checker.sv
// Port-level checks for the lidar zone obstacle detector, bound to the top level.
// Depends on lzod_pkg and the assertion macro header.
`default_nettype none

`include "lidar_zone_obstacle_detector_top_macros.svh"

module lzod_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire lzod_pkg::t_out_item o_out_item
);
    import lzod_pkg::*;

    logic w_stall;
    logic w_nest_ok;

    assign w_stall   = o_out_valid && !i_out_ready;
    // a close hit implies a mid hit, a mid hit implies a far hit
    assign w_nest_ok = (!o_out_item.far_clear || o_out_item.mid_clear)
                       && (!o_out_item.mid_clear || o_out_item.close_clear);

    `LZOD_ASSERT(a_out_hold, i_clk, i_rst_n, w_stall |=> o_out_valid)
    `LZOD_ASSERT(a_out_stable, i_clk, i_rst_n, w_stall |=> $stable(o_out_item))
    `LZOD_ASSERT(a_zone_nesting, i_clk, i_rst_n, o_out_valid |-> w_nest_ok)
    `LZOD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready))

endmodule

bind lidar_zone_obstacle_detector_top lzod_checker u_lzod_checker (.*);

`default_nettype wire
